// File: sv/dvpc_pkg.sv
`default_nettype none
package dvpc_pkg;

  localparam int COMPONENTS = 16;
  localparam int CIDX_W     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // weights in 0.1 mg units
  localparam int UNITS_HALF_GRAM = 5000;
  localparam int UNITS_MIN_PULSE = 6000;
  localparam int UNITS_AT_TARGET = 2500;

  // floor(x / 50) = (x * ceil(2^38 / 50)) >> 38 for any 32-bit x
  localparam logic [32:0] DIV50_MAGIC = 33'd5497558139;
  localparam int          DIV50_SHIFT = 38;

  localparam logic [1:0] OP_WEIGH = 2'd0;
  localparam logic [1:0] OP_RECAL = 2'd1;
  localparam logic [1:0] OP_SETPT = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] REG_INIT_TIME  = 3'd0;
  localparam logic [2:0] REG_INIT_AUTO  = 3'd1;
  localparam logic [2:0] REG_INCREMENT  = 3'd2;
  localparam logic [2:0] REG_AUTO_CYCLE = 3'd3;
  localparam logic [2:0] REG_FIXED_MIN  = 3'd4;
  localparam logic [2:0] REG_PULSING    = 3'd5;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] start_time_auto;
    logic [15:0] pulse_increment;
    logic        auto_cycle;
    logic        fixed_min_pulse_weight;
    logic [15:0] pulsing_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  component;
    logic [31:0] target_weight;
    logic [31:0] actual_weight;
    logic        first_pulse;
  } item_t;

  // per-component calibration record held in the memory
  typedef struct packed {
    logic [15:0] min_weight_time;
    logic [15:0] half_gram_time;
    logic [31:0] previous_weight;
    logic [26:0] required_pulse_weight;
  } rec_t;

  typedef struct packed {
    logic        at_target;
    logic [15:0] pulse_time;
    logic        calibrating;
  } res_t;

endpackage
`default_nettype wire

// File: sv/dvpc_ram.sv
`default_nettype none
module dvpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/dvpc_regs.sv
`default_nettype none
module dvpc_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output dvpc_pkg::cfg_t   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_time              <= 16'd50;
      cfg.start_time_auto         <= 16'd50;
      cfg.pulse_increment         <= 16'd5;
      cfg.auto_cycle              <= 1'b0;
      cfg.fixed_min_pulse_weight  <= 1'b0;
      cfg.pulsing_mask            <= 16'd0;
    end else if (wr) begin
      unique case (idx)
        dvpc_pkg::REG_INIT_TIME:  cfg.start_time              <= pwdata[15:0];
        dvpc_pkg::REG_INIT_AUTO:  cfg.start_time_auto         <= pwdata[15:0];
        dvpc_pkg::REG_INCREMENT:  cfg.pulse_increment         <= pwdata[15:0];
        dvpc_pkg::REG_AUTO_CYCLE: cfg.auto_cycle              <= pwdata[0];
        dvpc_pkg::REG_FIXED_MIN:  cfg.fixed_min_pulse_weight  <= pwdata[0];
        dvpc_pkg::REG_PULSING:    cfg.pulsing_mask            <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dvpc_pkg::REG_INIT_TIME:  prdata = {16'd0, cfg.start_time};
      dvpc_pkg::REG_INIT_AUTO:  prdata = {16'd0, cfg.start_time_auto};
      dvpc_pkg::REG_INCREMENT:  prdata = {16'd0, cfg.pulse_increment};
      dvpc_pkg::REG_AUTO_CYCLE: prdata = {31'd0, cfg.auto_cycle};
      dvpc_pkg::REG_FIXED_MIN:  prdata = {31'd0, cfg.fixed_min_pulse_weight};
      dvpc_pkg::REG_PULSING:    prdata = {16'd0, cfg.pulsing_mask};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/dvpc_core.sv
`default_nettype none
module dvpc_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dvpc_pkg::cfg_t        cfg,
  // record read, issued as an item enters the update stage
  input  wire logic                  rd_en,
  input  wire logic [3:0]            rd_component,
  // item in the update stage
  input  wire dvpc_pkg::item_t       item,
  input  wire logic [26:0]           quot,
  input  wire logic                  commit,
  output dvpc_pkg::res_t             res
);

  localparam int CW = dvpc_pkg::CIDX_W;

  logic [dvpc_pkg::COMPONENTS-1:0] flags, flags_next;
  logic [dvpc_pkg::COMPONENTS-1:0] entry_valid;
  logic [dvpc_pkg::COMPONENTS-1:0] mask;
  logic [15:0]     cpt, cpt_next;
  logic            hgc, hgc_next;

  dvpc_pkg::rec_t  ram_q, fwd, rec, rec_next;
  logic            fwd_hit, rd_valid;
  logic            we;
  logic [CW-1:0]   idx, rd_idx;
  logic            cv;

  logic [32:0]     err, added;
  logic [26:0]     req_calc;
  logic [16:0]     sum;
  logic [15:0]     sat, init_time;
  logic            flag;

  assign mask   = cfg.pulsing_mask[dvpc_pkg::COMPONENTS-1:0];
  assign idx    = item.component[CW-1:0];
  assign rd_idx = rd_component[CW-1:0];
  assign cv     = {1'b0, item.component} < 5'(dvpc_pkg::COMPONENTS);

  dvpc_ram #(
    .WIDTH ($bits(dvpc_pkg::rec_t)),
    .DEPTH (dvpc_pkg::COMPONENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we && commit),
    .waddr (idx),
    .wdata (rec_next),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // a write landing on the entry read at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd_hit     <= 1'b0;
      rd_valid    <= 1'b0;
    end else begin
      if (we && commit) begin
        entry_valid[idx] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit  <= we && commit && (idx == rd_idx);
        rd_valid <= entry_valid[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd <= rec_next;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rec = fwd;
    end else if (rd_valid) begin
      rec = ram_q;
    end else begin
      rec = '0;
    end
  end

  assign flag      = flags[idx];
  assign err       = {1'b0, item.target_weight} - {1'b0, item.actual_weight};
  assign added     = {1'b0, item.actual_weight} - {1'b0, rec.previous_weight};
  assign sum       = {1'b0, cpt} + {1'b0, cfg.pulse_increment};
  assign sat       = sum[16] ? 16'hFFFF : sum[15:0];
  assign init_time = cfg.auto_cycle ? cfg.start_time_auto : cfg.start_time;

  always_comb begin
    if (cfg.fixed_min_pulse_weight || quot < 27'(dvpc_pkg::UNITS_HALF_GRAM)) begin
      req_calc = 27'(dvpc_pkg::UNITS_MIN_PULSE);
    end else begin
      req_calc = quot;
    end
  end

  always_comb begin
    rec_next       = rec;
    cpt_next       = cpt;
    hgc_next       = hgc;
    flags_next     = flags;
    we             = 1'b0;
    res.at_target  = 1'b0;
    case (item.opcode)
      dvpc_pkg::OP_WEIGH: begin
        if (cv) begin
          we = 1'b1;
          if (item.first_pulse) begin
            if (flag) begin
              hgc_next                 = 1'b0;
              cpt_next                 = init_time;
              rec_next.min_weight_time = init_time;
            end else begin
              cpt_next = rec.min_weight_time;
            end
          end else if (flag) begin
            rec_next.required_pulse_weight = req_calc;
            if ($signed(added) > $signed(33'(dvpc_pkg::UNITS_MIN_PULSE)) && !hgc) begin
              rec_next.half_gram_time = cpt;
              hgc_next                = 1'b1;
            end
            if ($signed({added[32], added}) > $signed({7'd0, req_calc})) begin
              flags_next[idx]          = 1'b0;
              rec_next.min_weight_time = cpt;
            end else begin
              cpt_next = sat;
            end
          end else begin
            cpt_next = rec.min_weight_time;
          end
          rec_next.previous_weight = item.actual_weight;
          // final approach
          if ($signed({err[32], err}) < $signed({7'd0, rec_next.required_pulse_weight})) begin
            cpt_next = rec_next.half_gram_time;
          end
          if ($signed(err) < $signed(33'(dvpc_pkg::UNITS_AT_TARGET))) begin
            res.at_target = 1'b1;
            cpt_next      = rec_next.min_weight_time;
          end
        end
      end
      dvpc_pkg::OP_RECAL: begin
        flags_next = flags | mask;
      end
      dvpc_pkg::OP_SETPT: begin
        if (cv && mask[idx]) begin
          flags_next[idx] = 1'b1;
        end
      end
      default: ;
    endcase
    res.pulse_time  = cpt_next;
    res.calibrating = cv ? flags_next[idx] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      cpt   <= 16'd0;
      hgc   <= 1'b0;
    end else if (commit) begin
      flags <= flags_next;
      cpt   <= cpt_next;
      hgc   <= hgc_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/dosing_valve_pulse_calibrator.sv
// Stages: input register, divide, update and output register; one transaction per cycle
// unless m_tready holds the output. The record memory is read as an item enters the
// update stage and written as it leaves, with a forwarding register for the same entry.
// Reset (rst, synchronous) clears pipeline valids, calibration flags, pulse time and the
// per-entry valid bits; records never written read as zero, so no clearing pass is needed.
`default_nettype none
module dosing_valve_pulse_calibrator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] component, [35:4] target_weight, [67:36] actual_weight, [68] first_pulse
  input  wire logic [71:0] s_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] at_target, [16:1] pulse_time, [17] calibrating
  output logic      [23:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  dvpc_pkg::cfg_t  cfg;
  dvpc_pkg::item_t in_item, s0_item, s1_item, s2_item;
  dvpc_pkg::res_t  res;

  logic        s0_valid, s1_valid, s2_valid;
  logic        s0_adv, s1_adv, s2_adv;
  logic        s1_free, s2_free, out_free;
  logic [48:0] ph, pl;
  logic [64:0] prod;
  logic [26:0] s2_quot;

  dvpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item.opcode        = s_tuser;
  assign in_item.component     = s_tdata[3:0];
  assign in_item.target_weight = s_tdata[35:4];
  assign in_item.actual_weight = s_tdata[67:36];
  assign in_item.first_pulse   = s_tdata[68];

  assign out_free = !m_tvalid || m_tready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_adv;
  assign s0_adv   = s0_valid && s1_free;
  assign s_tready = !rst && (!s0_valid || s0_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) s0_valid <= s_tvalid;
      if (s1_free)  s1_valid <= s0_valid;
      if (s2_free)  s2_valid <= s1_valid;
      if (out_free) m_tvalid <= s2_valid;
    end
  end

  // target / 50 by reciprocal, split into two 16 x 33 partial products
  assign prod = {ph, 16'd0} + {16'd0, pl};

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s0_item <= in_item;
    end
    if (s0_adv) begin
      s1_item <= s0_item;
      ph      <= 49'(s0_item.target_weight[31:16]) * 49'(dvpc_pkg::DIV50_MAGIC);
      pl      <= 49'(s0_item.target_weight[15:0]) * 49'(dvpc_pkg::DIV50_MAGIC);
    end
    if (s1_adv) begin
      s2_item <= s1_item;
      s2_quot <= 27'(prod >> dvpc_pkg::DIV50_SHIFT);
    end
    if (s2_adv) begin
      m_tdata <= {6'd0, res.calibrating, res.pulse_time, res.at_target};
    end
  end

  dvpc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rd_en        (s1_adv),
    .rd_component (s1_item.component),
    .item         (s2_item),
    .quot         (s2_quot),
    .commit       (s2_adv),
    .res          (res)
  );

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> s0_valid)
    else $error("accepted transaction did not enter the pipeline");

  a_read_then_update : assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> s2_valid)
    else $error("record read issued without an item in the update stage");

  a_update_then_out : assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> m_tvalid)
    else $error("committed update produced no result");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s2_valid))
    else $error("result appeared with no item in the update stage");

endmodule
`default_nettype wire

// File: bench/dosing_valve_pulse_calibrator_check.sv
`timescale 1ns / 1ps
module dosing_valve_pulse_calibrator_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               failures,
  output int               pending
);

  logic [15:0] cfg_init;
  logic [15:0] cfg_init_auto;
  logic [15:0] cfg_incr;
  logic        cfg_auto;
  logic        cfg_fixed;
  logic [15:0] cfg_mask;

  logic [15:0] cal_flag;
  logic [15:0] min_time   [dvpc_pkg::COMPONENTS];
  logic [15:0] hg_time    [dvpc_pkg::COMPONENTS];
  logic [31:0] prev_wt    [dvpc_pkg::COMPONENTS];
  logic [26:0] req_wt     [dvpc_pkg::COMPONENTS];
  logic [15:0] cur_time;
  logic        hg_done;

  dvpc_pkg::res_t pulse_results_due [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic dvpc_pkg::res_t predict_pulse(dvpc_pkg::item_t it);
    dvpc_pkg::res_t r;
    logic [3:0]  c;
    longint      tgt_l;
    longint      act_l;
    longint      err;
    longint      added;
    longint      req_l;
    logic [31:0] req;
    logic [16:0] sum;
    c      = it.component;
    tgt_l  = it.target_weight;
    act_l  = it.actual_weight;
    err    = tgt_l - act_l;
    r.at_target = 1'b0;
    if (it.opcode == dvpc_pkg::OP_WEIGH) begin
      if (it.first_pulse) begin
        if (cal_flag[c]) begin
          hg_done     = 1'b0;
          cur_time    = cfg_auto ? cfg_init_auto : cfg_init;
          min_time[c] = cur_time;
        end else begin
          cur_time = min_time[c];
        end
      end else begin
        added = act_l - longint'(prev_wt[c]);
        if (cal_flag[c]) begin
          req = it.target_weight / 50;
          if (req < dvpc_pkg::UNITS_HALF_GRAM) req = dvpc_pkg::UNITS_MIN_PULSE;
          if (cfg_fixed) req = dvpc_pkg::UNITS_MIN_PULSE;
          req_wt[c] = req[26:0];
          req_l     = req;
          if (added > dvpc_pkg::UNITS_MIN_PULSE && !hg_done) begin
            hg_time[c] = cur_time;
            hg_done    = 1'b1;
          end
          if (added > req_l) begin
            cal_flag[c] = 1'b0;
            min_time[c] = cur_time;
          end else begin
            sum      = {1'b0, cur_time} + {1'b0, cfg_incr};
            cur_time = sum[16] ? 16'hFFFF : sum[15:0];
          end
        end else begin
          cur_time = min_time[c];
        end
      end
      prev_wt[c] = it.actual_weight;
      req_l = req_wt[c];
      // final approach uses the half-gram time
      if (err < req_l) cur_time = hg_time[c];
      if (err < dvpc_pkg::UNITS_AT_TARGET) begin
        r.at_target = 1'b1;
        cur_time    = min_time[c];
      end
    end else if (it.opcode == dvpc_pkg::OP_RECAL) begin
      cal_flag = cal_flag | cfg_mask;
    end else if (it.opcode == dvpc_pkg::OP_SETPT) begin
      if (cfg_mask[c]) cal_flag[c] = 1'b1;
    end
    r.pulse_time  = cur_time;
    r.calibrating = cal_flag[c];
    return r;
  endfunction

  always @(posedge clk) begin
    dvpc_pkg::item_t it;
    dvpc_pkg::res_t  got;
    dvpc_pkg::res_t  due;
    if (rst) begin
      cfg_init      = 16'd50;
      cfg_init_auto = 16'd50;
      cfg_incr      = 16'd5;
      cfg_auto      = 1'b0;
      cfg_fixed     = 1'b0;
      cfg_mask      = '0;
      cal_flag      = '0;
      for (int i = 0; i < dvpc_pkg::COMPONENTS; i++) begin
        min_time[i] = '0;
        hg_time[i]  = '0;
        prev_wt[i]  = '0;
        req_wt[i]   = '0;
      end
      cur_time = '0;
      hg_done  = 1'b0;
      pulse_results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          dvpc_pkg::REG_INIT_TIME:  cfg_init      = pwdata[15:0];
          dvpc_pkg::REG_INIT_AUTO:  cfg_init_auto = pwdata[15:0];
          dvpc_pkg::REG_INCREMENT:  cfg_incr      = pwdata[15:0];
          dvpc_pkg::REG_AUTO_CYCLE: cfg_auto      = pwdata[0];
          dvpc_pkg::REG_FIXED_MIN:  cfg_fixed     = pwdata[0];
          dvpc_pkg::REG_PULSING:    cfg_mask      = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        it.opcode        = s_tuser;
        it.component     = s_tdata[3:0];
        it.target_weight = s_tdata[35:4];
        it.actual_weight = s_tdata[67:36];
        it.first_pulse   = s_tdata[68];
        pulse_results_due.push_back(predict_pulse(it));
      end
      if (m_tvalid && m_tready) begin
        got.at_target   = m_tdata[0];
        got.pulse_time  = m_tdata[16:1];
        got.calibrating = m_tdata[17];
        if (pulse_results_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected transaction: at_target %0b pulse_time %0d calibrating %0b",
                   $time, got.at_target, got.pulse_time, got.calibrating);
        end else begin
          due = pulse_results_due.pop_front();
          if (got.at_target !== due.at_target) begin
            failures++;
            $display("%0t: at_target expected %0b actual %0b",
                     $time, due.at_target, got.at_target);
          end
          if (got.pulse_time !== due.pulse_time) begin
            failures++;
            $display("%0t: pulse_time expected %0d actual %0d",
                     $time, due.pulse_time, got.pulse_time);
          end
          if (got.calibrating !== due.calibrating) begin
            failures++;
            $display("%0t: calibrating expected %0b actual %0b",
                     $time, due.calibrating, got.calibrating);
          end
        end
      end
    end
    pending = pulse_results_due.size();
  end

endmodule

// File: bench/dosing_valve_pulse_calibrator_test.sv
`timescale 1ns / 1ps
module dosing_valve_pulse_calibrator_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 205;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int failures;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_len = 0;
  logic fixed_min = 1'b0;

  dosing_valve_pulse_calibrator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dosing_valve_pulse_calibrator_check valve_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .failures (failures),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold-off counted down here
  always @(negedge clk) begin
    if (rx_hold_len > 0) begin
      m_tready <= 1'b0;
      rx_hold_len--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] c, logic [31:0] tgt,
                           logic [31:0] act, logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, first, act, tgt, c};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(3)), 4'($urandom_range(15)), $urandom, $urandom,
              1'($urandom_range(1)));
  endtask

  // let the block drain before a register write or a deliberate pause
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] init, logic [15:0] init_auto, logic [15:0] incr,
                            logic auto_c, logic fixed, logic [15:0] mask);
    apb_write(dvpc_pkg::REG_INIT_TIME,  {16'd0, init});
    apb_write(dvpc_pkg::REG_INIT_AUTO,  {16'd0, init_auto});
    apb_write(dvpc_pkg::REG_INCREMENT,  {16'd0, incr});
    apb_write(dvpc_pkg::REG_AUTO_CYCLE, {31'd0, auto_c});
    apb_write(dvpc_pkg::REG_FIXED_MIN,  {31'd0, fixed});
    apb_write(dvpc_pkg::REG_PULSING,    {16'd0, mask});
    fixed_min = fixed;
  endtask

  // one dosing run on a component: optional RECAL or SETPT, first pulse, calibration steps, final approach
  task automatic dose_run();
    logic [3:0]  c;
    logic [31:0] tgt;
    logic [31:0] act;
    logic [31:0] req;
    logic [31:0] delta;
    logic [32:0] sum;
    c = 4'($urandom_range(15));
    case ($urandom_range(9))
      0:       tgt = $urandom_range(249999);
      1, 2:    tgt = $urandom;
      default: tgt = $urandom_range(2000000, 50000);
    endcase
    req = tgt / 50;
    if (req < dvpc_pkg::UNITS_HALF_GRAM || fixed_min) req = dvpc_pkg::UNITS_MIN_PULSE;
    act = $urandom_range(tgt >> 2);
    case ($urandom_range(9))
      0, 1, 2: send_item(dvpc_pkg::OP_RECAL, c, $urandom, $urandom, 1'($urandom_range(1)));
      3, 4:    send_item(dvpc_pkg::OP_SETPT, c, $urandom, $urandom, 1'($urandom_range(1)));
      default: ;
    endcase
    send_item(dvpc_pkg::OP_WEIGH, c, tgt, act, 1'b1);
    repeat ($urandom_range(14, 2)) begin
      case ($urandom_range(7))
        0:       delta = req;
        1:       delta = req + 1;
        2:       delta = dvpc_pkg::UNITS_MIN_PULSE;
        3:       delta = dvpc_pkg::UNITS_MIN_PULSE + 1;
        4:       delta = $urandom_range(req * 2);
        default: delta = $urandom_range(req);
      endcase
      if ($urandom_range(15) == 0) begin
        act = act - $urandom_range(act >> 3);
      end else begin
        sum = {1'b0, act} + {1'b0, delta};
        act = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      if ($urandom_range(9) == 0) send_noise();
      send_item(dvpc_pkg::OP_WEIGH, c, tgt, act, 1'b0);
    end
    if ($urandom_range(3) == 0 || tgt < 32'd5000)
      act = tgt + $urandom_range(20000);
    else
      act = tgt - $urandom_range(5000);
    send_item(dvpc_pkg::OP_WEIGH, c, tgt, act, 1'b0);
  endtask

  initial begin
    int phase_end;
    bit paused;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    settle();

    // directed: threshold edges and every opcode
    set_config(16'd100, 16'd200, 16'd10, 1'b0, 1'b0, 16'h5555);
    send_item(dvpc_pkg::OP_RECAL, 4'd0, 32'd0, 32'd0, 1'b0);
    send_item(dvpc_pkg::OP_SETPT, 4'd1, 32'd0, 32'd0, 1'b0);   // not pulsing: no effect
    send_item(dvpc_pkg::OP_SETPT, 4'd2, 32'd0, 32'd0, 1'b0);
    send_item(dvpc_pkg::OP_SPARE, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd0, 1'b1);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd3000, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd9000, 1'b0);   // adds exactly 0.6 g
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd15001, 1'b0);  // just over 0.6 g
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd15001, 1'b1);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd98000, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd100000, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd0, 32'd100000, 32'd120000, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd2, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(dvpc_pkg::OP_WEIGH, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd15, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_item(dvpc_pkg::OP_WEIGH, 4'd4, 32'd250000, 32'd0, 1'b1);
    send_item(dvpc_pkg::OP_WEIGH, 4'd4, 32'd250000, 32'd5000, 1'b0);   // equals required weight
    send_item(dvpc_pkg::OP_WEIGH, 4'd4, 32'd250000, 32'd10001, 1'b0);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: set_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF);
        1: set_config(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1, 16'h0000);
        3: set_config(16'd50, 16'd50, 16'd5, 1'b0, 1'b0, 16'hFFFF);
        5: set_config(16'($urandom_range(200, 20)), 16'($urandom_range(200, 20)),
                      16'($urandom_range(50, 1)), 1'($urandom_range(1)), 1'b0, 16'hFFFF);
        default:
          set_config(16'($urandom_range(200, 20)), 16'($urandom_range(200, 20)),
                     16'($urandom_range(50, 1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 16'($urandom));
      endcase
      if (p < 2) begin
        tx_idle_pct = 35;
        rx_idle_pct = 84;
      end else if (p < 4) begin
        tx_idle_pct = 84;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while items keep coming
      if (p == 4) rx_hold_len = 400;
      paused    = 1'b0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (p == 5 && !paused && items_sent > phase_end - 100) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(9) == 0) send_noise();
        else dose_run();
      end
    end

    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
